>>> hdl/addressed_frame_receiver_table_macros.svh
// assertion macros used by the frame receiver top level
`ifndef ADDRESSED_FRAME_RECEIVER_TABLE_MACROS_SVH
`define ADDRESSED_FRAME_RECEIVER_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define AFRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define AFRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/afrt_pkg.sv
// types and constants of the addressed frame receiver
package afrt_pkg;

    // frame position, also the header byte index for source .. size
    typedef enum logic [2:0] {
        PH_DEST  = 3'd0,
        PH_SRC   = 3'd1,
        PH_SEQ   = 3'd2,
        PH_CMD   = 3'd3,
        PH_CHAN  = 3'd4,
        PH_SIZE  = 3'd5,
        PH_DATA  = 3'd6,
        PH_CHECK = 3'd7
    } phase_t;

    localparam logic [1:0] ACT_RECEIVE = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    localparam logic [2:0] ST_IGNORED  = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_GOOD     = 3'd2;
    localparam logic [2:0] ST_BAD      = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    localparam int HDR_BYTES = 6;
    localparam logic [2:0] HDR_DEST = 3'd0;
    localparam logic [2:0] HDR_SRC  = 3'd1;
    localparam logic [2:0] HDR_SEQ  = 3'd2;
    localparam logic [2:0] HDR_CMD  = 3'd3;
    localparam logic [2:0] HDR_CHAN = 3'd4;
    localparam logic [2:0] HDR_SIZE = 3'd5;

    localparam logic [7:0] BROADCAST = 8'hFF;

    localparam int APB_ADDR_W = 3;
    localparam logic REG_OWN_ADDRESS = 1'b0;

endpackage

>>> hdl/addressed_frame_receiver_table.sv
// addressed frame receiver with slot table, top level
//
// Takes one item per clock while results are taken: a received byte with its
// address mark, a slot release or a slot read. Each item passes an input
// register, where the frame state, the slot valid bits and the free/ready slot
// searches are updated, and then a result register, from which the result is
// offered; the block sustains one item per cycle as long as results are taken.
// The loop through the rotating slot search sets the rate. Frame data sits
// in a ram of TABLE_DEPTH rows of DATA_BYTES (rounded up to a power of two)
// bytes, read when the item is taken in; headers and valid bits are
// flip-flops, and valid bits clear at reset, so there is no clearing pass.
`include "addressed_frame_receiver_table_macros.svh"

module addressed_frame_receiver_table
    import afrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 8,
    parameter int DATA_BYTES  = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // rx_byte[7:0], slot[10:8], data_offset[18:11]
    input  logic [2:0]            s_tuser,   // action[1:0], address_mark[2]
    // stream out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // frame_slot[2:0], ready_any[3], ready_slot[6:4],
                                             // rd_valid[7], rd_dest[15:8], rd_src[23:16],
                                             // rd_seq[31:24], rd_cmd[39:32], rd_chan[47:40],
                                             // rd_size[55:48], rd_data[63:56]
    output logic [2:0]            m_tuser,   // status[2:0]
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int SW        = $clog2(TABLE_DEPTH);
    localparam int OFF_W     = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam int AW        = SW + OFF_W;
    localparam int RAM_DEPTH = TABLE_DEPTH * (2 ** OFF_W);
    localparam int CMPW      = (SW + 1 > 3) ? SW + 1 : 3;

    // rotating search for a set bit from start, returns {found, index}
    function automatic logic [SW:0] find_from(input logic [TABLE_DEPTH-1:0] vec,
                                              input logic [SW-1:0] start);
        logic [2*TABLE_DEPTH-1:0] dbl;
        logic [TABLE_DEPTH-1:0]   rot;
        logic [SW:0]              pos;
        logic                     found;
        dbl   = {vec, vec} >> start;
        rot   = dbl[TABLE_DEPTH-1:0];
        found = 1'b0;
        pos   = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (rot[i])
            begin
                found = 1'b1;
                pos   = (SW+1)'(i);
            end
        end
        pos = pos + {1'b0, start};
        if (pos >= (SW+1)'(TABLE_DEPTH))
        begin
            pos = pos - (SW+1)'(TABLE_DEPTH);
        end
        return {found, pos[SW-1:0]};
    endfunction

    // handshake
    logic stage_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic accept;

    // input register
    logic [1:0] action_reg;
    logic [7:0] rx_byte_reg;
    logic       mark_reg;
    logic [2:0] slot_reg;
    logic [7:0] offset_reg;

    // block state
    logic [7:0]             own_address_reg;
    logic [TABLE_DEPTH-1:0] slot_valid_reg, slot_valid_next;
    phase_t                 phase_reg, phase_next;
    logic [7:0]             data_count_reg, data_count_next;
    logic [7:0]             running_sum_reg, running_sum_next;
    logic [SW-1:0]          cur_slot_reg, cur_slot_next;
    logic                   slot_none_reg, slot_none_next;
    logic [7:0]             size_reg, size_next;
    logic [7:0]             hdr_reg [TABLE_DEPTH][HDR_BYTES];

    // stage logic
    phase_t        phase_eff;
    logic [SW-1:0] sl_idx;
    logic          sl_ok;
    logic          off_ok;
    logic [SW:0]   free_hit;
    logic [SW:0]   ready_hit;
    logic [2:0]    status_c;
    logic          hdr_we;
    logic [SW-1:0] hdr_slot;
    logic [2:0]    hdr_idx;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    rd_data_c;
    logic [63:0]   tdata_c;
    logic [7:0]    rd_bytes_c [HDR_BYTES];
    logic          rd_valid_c;
    logic [2:0]    frame_slot_c;
    logic [2:0]    ready_slot_c;

    // ram read side and write-through bypass
    logic [AW-1:0] ram_raddr;
    logic          ram_re;
    logic [7:0]    ram_q;
    logic [7:0]    ram_src;
    logic          byp_reg;
    logic [7:0]    byp_data_reg;

    // result register
    logic [63:0] out_tdata_reg;
    logic [2:0]  out_status_reg;

    assign advance  = stage_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !stage_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_OWN_ADDRESS) ? {24'd0, own_address_reg}
                                                               : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= 8'd0;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr[APB_ADDR_W-1:2] == REG_OWN_ADDRESS)
        begin
            own_address_reg <= pwdata[7:0];
        end
    end

    // read address is taken straight from the incoming transfer
    assign ram_raddr = {SW'(s_tdata[10:8]), OFF_W'(s_tdata[18:11])};
    assign ram_re    = accept && s_tuser[1:0] == ACT_READ &&
                       CMPW'(s_tdata[10:8]) < CMPW'(TABLE_DEPTH) &&
                       9'(s_tdata[18:11]) < 9'(DATA_BYTES);

    afrt_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (ram_we && advance),
        .waddr (ram_waddr),
        .wdata (rx_byte_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // a byte written at the same edge as the read would be missed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byp_reg      <= ram_we && advance && ram_waddr == ram_raddr;
            byp_data_reg <= rx_byte_reg;
        end
    end

    assign ram_src = byp_reg ? byp_data_reg : ram_q;

    // one item of work
    always_comb
    begin
        sl_idx    = SW'(slot_reg);
        sl_ok     = CMPW'(slot_reg) < CMPW'(TABLE_DEPTH);
        off_ok    = 9'(offset_reg) < 9'(DATA_BYTES);
        phase_eff = mark_reg ? PH_DEST : phase_reg;
        free_hit  = find_from(~slot_valid_reg, slot_none_reg ? '0 : cur_slot_reg);

        slot_valid_next  = slot_valid_reg;
        phase_next       = phase_reg;
        data_count_next  = data_count_reg;
        running_sum_next = running_sum_reg;
        cur_slot_next    = cur_slot_reg;
        slot_none_next   = slot_none_reg;
        size_next        = size_reg;
        status_c         = ST_IGNORED;
        hdr_we           = 1'b0;
        hdr_slot         = cur_slot_reg;
        hdr_idx          = HDR_DEST;
        ram_we           = 1'b0;
        ram_waddr        = {cur_slot_reg, OFF_W'(data_count_reg)};
        rd_valid_c       = 1'b0;
        rd_data_c        = 8'd0;
        for (int k = 0; k < HDR_BYTES; k++)
        begin
            rd_bytes_c[k] = 8'd0;
        end

        case (action_reg)
            ACT_RECEIVE:
            begin
                // an unmarked byte while waiting for a destination is dropped
                if (phase_eff != PH_DEST || mark_reg)
                begin
                    phase_next = phase_eff;
                    unique case (phase_eff) inside
                        PH_DEST:
                        begin
                            if (!free_hit[SW])
                            begin
                                slot_none_next = 1'b1;
                                cur_slot_next  = '0;
                                status_c       = ST_FULL;
                            end
                            else
                            begin
                                slot_none_next = 1'b0;
                                cur_slot_next  = free_hit[SW-1:0];
                                if (rx_byte_reg == own_address_reg || rx_byte_reg == BROADCAST)
                                begin
                                    hdr_we           = 1'b1;
                                    hdr_slot         = free_hit[SW-1:0];
                                    hdr_idx          = HDR_DEST;
                                    running_sum_next = rx_byte_reg;
                                    data_count_next  = 8'd0;
                                    phase_next       = PH_SRC;
                                    status_c         = ST_ACCEPTED;
                                end
                            end
                        end
                        PH_SRC, PH_SEQ, PH_CMD, PH_CHAN, PH_SIZE:
                        begin
                            hdr_we           = 1'b1;
                            hdr_idx          = 3'(phase_eff);
                            running_sum_next = running_sum_reg + rx_byte_reg;
                            data_count_next  = 8'd0;
                            phase_next       = phase_t'(3'(phase_eff) + 3'd1);
                            status_c         = ST_ACCEPTED;
                            if (phase_eff == PH_SIZE)
                            begin
                                size_next = rx_byte_reg;
                            end
                        end
                        PH_DATA:
                        begin
                            // bytes past the row are summed but not kept
                            ram_we           = 9'(data_count_reg) < 9'(DATA_BYTES);
                            running_sum_next = running_sum_reg + rx_byte_reg;
                            status_c         = ST_ACCEPTED;
                            if (size_reg != 8'd0 &&
                                9'(data_count_reg) + 9'd1 < 9'(size_reg))
                            begin
                                data_count_next = data_count_reg + 8'd1;
                            end
                            else
                            begin
                                data_count_next = 8'd0;
                                phase_next      = PH_CHECK;
                            end
                        end
                        PH_CHECK:
                        begin
                            if (~running_sum_reg == rx_byte_reg)
                            begin
                                slot_valid_next[cur_slot_reg] = 1'b1;
                                status_c = ST_GOOD;
                            end
                            else
                            begin
                                status_c = ST_BAD;
                            end
                            phase_next       = PH_DEST;
                            running_sum_next = 8'd0;
                        end
                        default:
                        begin
                            phase_next = PH_DEST;
                        end
                    endcase
                end
            end
            ACT_RELEASE:
            begin
                if (sl_ok)
                begin
                    slot_valid_next[sl_idx] = 1'b0;
                end
                status_c = ST_DONE;
            end
            ACT_READ:
            begin
                if (sl_ok)
                begin
                    rd_valid_c = slot_valid_reg[sl_idx];
                    for (int k = 0; k < HDR_BYTES; k++)
                    begin
                        rd_bytes_c[k] = hdr_reg[sl_idx][k];
                    end
                    if (off_ok)
                    begin
                        rd_data_c = ram_src;
                    end
                end
                status_c = ST_DONE;
            end
            default:
            begin
                status_c = ST_IGNORED;
            end
        endcase

        // report from the state after this item
        ready_hit    = find_from(slot_valid_next, slot_none_next ? '0 : cur_slot_next);
        frame_slot_c = slot_none_next ? 3'd0 : 3'(cur_slot_next);
        ready_slot_c = ready_hit[SW] ? 3'(ready_hit[SW-1:0]) : 3'd0;
        tdata_c      = {rd_data_c,
                        rd_bytes_c[HDR_SIZE], rd_bytes_c[HDR_CHAN], rd_bytes_c[HDR_CMD],
                        rd_bytes_c[HDR_SEQ], rd_bytes_c[HDR_SRC], rd_bytes_c[HDR_DEST],
                        rd_valid_c, ready_slot_c, ready_hit[SW], frame_slot_c};
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            slot_valid_reg  <= '0;
            phase_reg       <= PH_DEST;
            data_count_reg  <= 8'd0;
            running_sum_reg <= 8'd0;
            cur_slot_reg    <= '0;
            slot_none_reg   <= 1'b0;
            size_reg        <= 8'd0;
        end
        else
        begin
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                slot_valid_reg  <= slot_valid_next;
                phase_reg       <= phase_next;
                data_count_reg  <= data_count_next;
                running_sum_reg <= running_sum_next;
                cur_slot_reg    <= cur_slot_next;
                slot_none_reg   <= slot_none_next;
                size_reg        <= size_next;
            end
        end
    end

    // payload: input register, headers, result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg  <= s_tuser[1:0];
            mark_reg    <= s_tuser[2];
            rx_byte_reg <= s_tdata[7:0];
            slot_reg    <= s_tdata[10:8];
            offset_reg  <= s_tdata[18:11];
        end
        if (advance)
        begin
            out_tdata_reg  <= tdata_c;
            out_status_reg <= status_c;
            if (hdr_we)
            begin
                hdr_reg[hdr_slot][hdr_idx] <= rx_byte_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_status_reg;

    `AFRT_ASSERT_IMP(a_none_means_slot_zero, slot_none_reg, cur_slot_reg == '0,
        "current slot not zero while no slot is held")
    `AFRT_ASSERT_IMP(a_frame_holds_slot, phase_reg != PH_DEST, !slot_none_reg,
        "frame in progress without a held slot")
    `AFRT_ASSERT_IMP(a_data_write_in_data_phase, ram_we && advance,
        phase_reg == PH_DATA && !mark_reg,
        "data ram written outside the data phase")
    `AFRT_ASSERT_NXT(a_good_frame_marks_slot, advance && status_c == ST_GOOD,
        slot_valid_reg[$past(cur_slot_reg)],
        "good frame did not mark its slot valid")

endmodule

>>> hdl/afrt_ram.sv
// generic single-write, single-read ram with registered read data
module afrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
